FILE: rtl/rtpd_pkg.sv
// Shared constants, codes and command types of the RTP H.264/H.265 depacketizer.
`timescale 1ns / 1ps

package rtpd_pkg;

  // Buffer and framing sizes.
  localparam int unsigned BUF_BYTES        = 262144;
  localparam int unsigned RTP_HEADER_BYTES = 12;
  localparam int unsigned START_CODE_BYTES = 4;

  // Widths derived from the buffer size; the cursor must hold BUF_BYTES itself.
  localparam int unsigned CUR_W  = $clog2(BUF_BYTES + 1);
  localparam int unsigned ADDR_W = $clog2(BUF_BYTES);

  // Fixed widths of the result length and the datagram position.
  localparam int unsigned LEN_W = 19;
  localparam int unsigned POS_W = 19;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Queue depths.
  localparam int unsigned CQ_DEPTH = 4;
  localparam int unsigned OQ_DEPTH = 4;

  // NAL unit type codes.
  localparam logic [4:0] AVC_TYPE_SPS  = 5'd7;
  localparam logic [4:0] AVC_TYPE_FU   = 5'd28;
  localparam logic [5:0] HEVC_TYPE_VPS = 6'd32;
  localparam logic [5:0] HEVC_TYPE_FU  = 6'd49;

  // Masks used to rebuild fragmented NAL headers and to spot an RTP header.
  localparam logic [7:0] AVC_HDR_MASK    = 8'hE0;
  localparam logic [7:0] AVC_TYPE_MASK   = 8'h1F;
  localparam logic [7:0] HEVC_HDR_MASK   = 8'h81;
  localparam logic [7:0] RTP_VER_MASK    = 8'h80;
  localparam logic [7:0] RTP_CHECK_MASK  = 8'h60;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_DRAIN_BYTE  = 3'd0,
    ST_DRAIN_EMPTY = 3'd1,
    ST_NOTHING     = 3'd2,
    ST_READY       = 3'd3,
    ST_HELD        = 3'd4,
    ST_DROPPED     = 3'd5
  } status_e;

  // Operation carried by one command word.
  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_DRAIN = 1'b1
  } cmd_op_e;

  // What happens at the end of a datagram.
  typedef enum logic [1:0] {
    END_NONE    = 2'd0,
    END_PLAIN   = 2'd1,
    END_SHORT   = 2'd2,
    END_RELEASE = 2'd3
  } end_e;

  // One command word from the front to the back.
  typedef struct packed {
    cmd_op_e    op;
    logic       start;
    logic [1:0] nwr;
    logic [7:0] v0;
    logic [7:0] v1;
    end_e       end_class;
    logic       pss;
  } cmd_t;

endpackage

FILE: rtl/rtpd_front.sv
// Front end: tracks datagram position and packet type and turns each word into a command.
`timescale 1ns / 1ps

module rtpd_front
  import rtpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic       opcode_i,
  input  logic [7:0] byte_in_i,
  input  logic       datagram_end_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  localparam int unsigned PL_W = POS_W + 1;

  typedef enum logic [1:0] {
    KIND_SINGLE  = 2'd0,
    KIND_AVC_FU  = 2'd1,
    KIND_HEVC_FU = 2'd2
  } kind_e;

  logic [POS_W-1:0] pos_q, pos_d;
  logic             hdr_on_q, hdr_on_d;
  logic [7:0]       held0_q, held0_d;
  logic [7:0]       held1_q, held1_d;
  kind_e            kind_q, kind_d;
  logic [1:0]       flags_q, flags_d;
  logic             pss_q, pss_d;

  logic             p0_en;
  logic [7:0]       p0_byte;
  logic             pn_en;
  logic [POS_W-1:0] pn_idx;
  logic [PL_W-1:0]  count;
  logic [PL_W-1:0]  hdr_len;
  logic [PL_W-1:0]  plen;
  logic             is_short;
  logic             rel_nal;
  logic             accept_data;
  cmd_t             cmd;

  // Append one store write to a command.
  function automatic cmd_t add_write(cmd_t c, logic [7:0] v);
    cmd_t r;
    r = c;
    if (c.nwr == 2'd0) begin
      r.v0  = v;
      r.nwr = 2'd1;
    end else begin
      r.v1  = v;
      r.nwr = 2'd2;
    end
    return r;
  endfunction

  // Classify the word and build its command.
  always_comb begin
    pos_d    = pos_q;
    hdr_on_d = hdr_on_q;
    held0_d  = held0_q;
    held1_d  = held1_q;
    kind_d   = kind_q;
    flags_d  = flags_q;
    pss_d    = pss_q;
    p0_en    = 1'b0;
    p0_byte  = byte_in_i;
    pn_en    = 1'b0;
    pn_idx   = '0;
    count    = '0;
    hdr_len  = '0;
    plen     = '0;
    is_short = 1'b0;
    rel_nal  = 1'b0;
    cmd           = '0;
    cmd.op        = OP_BYTE;
    cmd.end_class = END_NONE;

    if (opcode_i == OP_DRAIN) begin
      cmd.op = OP_DRAIN;
    end else begin
      // Decide which payload byte, if any, this datagram word is.
      if (pos_q == '0) begin
        held0_d  = byte_in_i;
        hdr_on_d = 1'b0;
        p0_en    = datagram_end_i;
      end else if (pos_q == POS_W'(1)) begin
        hdr_on_d = ((held0_q & RTP_VER_MASK) != '0) && ((byte_in_i & RTP_CHECK_MASK) != '0);
        if (!hdr_on_d) begin
          p0_en   = 1'b1;
          p0_byte = held0_q;
          pn_en   = 1'b1;
          pn_idx  = POS_W'(1);
        end
      end else if (hdr_on_q) begin
        if (pos_q == POS_W'(RTP_HEADER_BYTES)) begin
          p0_en = 1'b1;
        end else if (pos_q > POS_W'(RTP_HEADER_BYTES)) begin
          pn_en  = 1'b1;
          pn_idx = pos_q - POS_W'(RTP_HEADER_BYTES);
        end
      end else begin
        pn_en  = 1'b1;
        pn_idx = pos_q;
      end

      // First payload byte: the NAL header or the FU indicator.
      if (p0_en) begin
        held0_d = p0_byte;
        if (((p0_byte & AVC_TYPE_MASK) == {3'b000, AVC_TYPE_SPS}) ||
            (p0_byte[6:1] == HEVC_TYPE_VPS)) begin
          pss_d = 1'b1;
        end
        if ((p0_byte & AVC_TYPE_MASK) == {3'b000, AVC_TYPE_FU}) begin
          kind_d = KIND_AVC_FU;
        end else if (p0_byte[6:1] == HEVC_TYPE_FU) begin
          kind_d = KIND_HEVC_FU;
        end else begin
          kind_d    = KIND_SINGLE;
          cmd.start = 1'b1;
          cmd       = add_write(cmd, p0_byte);
        end
      end

      // Later payload bytes: FU headers, the second H.265 header byte, or data.
      if (pn_en) begin
        if (pn_idx == POS_W'(1)) begin
          held1_d = byte_in_i;
          case (kind_d)
            KIND_AVC_FU: begin
              flags_d = {byte_in_i[7], byte_in_i[6]};
              if (byte_in_i[7]) begin
                cmd.start = 1'b1;
                cmd = add_write(cmd, (held0_d & AVC_HDR_MASK) | (byte_in_i & AVC_TYPE_MASK));
              end
            end
            KIND_HEVC_FU: begin
              flags_d = flags_q;
            end
            default: begin
              cmd = add_write(cmd, byte_in_i);
            end
          endcase
        end else if ((pn_idx == POS_W'(2)) && (kind_d == KIND_HEVC_FU)) begin
          flags_d = {byte_in_i[7], byte_in_i[6]};
          if (byte_in_i[7]) begin
            cmd.start = 1'b1;
            cmd = add_write(cmd, (held0_d & HEVC_HDR_MASK) | {1'b0, byte_in_i[5:0], 1'b0});
            cmd = add_write(cmd, held1_d);
          end
        end else begin
          cmd = add_write(cmd, byte_in_i);
        end
      end

      if (pos_q < POS_MAX) begin
        pos_d = pos_q + POS_W'(1);
      end

      // Classify the end of the datagram, then start over.
      if (datagram_end_i) begin
        count   = PL_W'(pos_q) + PL_W'(1);
        hdr_len = hdr_on_d ? PL_W'(RTP_HEADER_BYTES) : '0;
        plen    = (count > hdr_len) ? (count - hdr_len) : '0;
        is_short = (plen == '0) ||
                   ((kind_d == KIND_AVC_FU) && (plen < PL_W'(2))) ||
                   ((kind_d == KIND_HEVC_FU) && (plen < PL_W'(3)));
        rel_nal  = (kind_d == KIND_SINGLE) || (!flags_d[1] && flags_d[0]);
        if (is_short) begin
          cmd.end_class = END_SHORT;
        end else if (rel_nal) begin
          cmd.end_class = END_RELEASE;
        end else begin
          cmd.end_class = END_PLAIN;
        end
        cmd.pss  = pss_d;
        pos_d    = '0;
        kind_d   = KIND_SINGLE;
        flags_d  = 2'b00;
        hdr_on_d = 1'b0;
      end
    end
  end

  // A word that changes nothing downstream is not queued.
  assign accept_data = push_i && !full_i && (opcode_i == OP_BYTE);
  assign cmd_push_o  = push_i && !full_i &&
                       ((cmd.op == OP_DRAIN) || cmd.start || (cmd.nwr != 2'd0) ||
                        (cmd.end_class != END_NONE));
  assign cmd_o = cmd;

  // Datagram tracking state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hdr_on_q <= 1'b0;
      held0_q  <= '0;
      held1_q  <= '0;
      kind_q   <= KIND_SINGLE;
      flags_q  <= 2'b00;
      pss_q    <= 1'b0;
    end else if (accept_data) begin
      pos_q    <= pos_d;
      hdr_on_q <= hdr_on_d;
      held0_q  <= held0_d;
      held1_q  <= held1_d;
      kind_q   <= kind_d;
      flags_q  <= flags_d;
      pss_q    <= pss_d;
    end
  end

endmodule

FILE: rtl/rtpd_cmd_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module rtpd_cmd_queue
  import rtpd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PTR_W = $clog2(CQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(CQ_DEPTH + 1);

  cmd_t             slot_q [CQ_DEPTH];
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CNT_W'(CQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[head_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      tail_d = (tail_q == PTR_W'(CQ_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
    end
    if (do_pop) begin
      head_d = (head_q == PTR_W'(CQ_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // Command storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[tail_q] <= cmd_i;
    end
  end

endmodule

FILE: rtl/rtpd_back.sv
// Back end: NAL buffer writes, release and drain, read stage and result queue.
`timescale 1ns / 1ps

module rtpd_back
  import rtpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [2:0]       status_o,
  output logic [7:0]       byte_out_o,
  output logic             byte_last_o,
  output logic [LEN_W-1:0] nal_length_o
);

  localparam int unsigned BANK_W   = $clog2(START_CODE_BYTES);
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    status_e          status;
    logic [7:0]       data;
    logic             last;
    logic [LEN_W-1:0] len;
  } res_t;

  // NAL buffer state.
  logic [CUR_W-1:0] cur_q, cur_d;
  logic [CUR_W-1:0] ready_q, ready_d;
  logic [CUR_W-1:0] drain_q, drain_d;
  logic             err_q, err_d;
  logic             step_q, step_d;

  // The first bytes of the buffer sit in flops so a whole start code is written at once.
  logic [7:0]       bank_q [START_CODE_BYTES];
  logic [7:0]       nal_mem_q [BUF_BYTES];
  logic [7:0]       mem_rd_q;
  logic [7:0]       bank_rd_q;
  logic             rd_bank_q;

  // Read stage and result queue.
  logic                s2_valid_q;
  res_t                s2_res_q;
  logic                s2_mem_q;
  res_t                oq_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_head_q, oq_tail_q;
  logic [OQ_CNT_W-1:0] oq_cnt_q;

  logic             wr_now;
  logic [7:0]       wr_val;
  logic             last_step;
  logic             makes_res;
  logic [OQ_CNT_W:0] occ;
  logic             room;
  logic             go;
  logic             do_start;
  logic [CUR_W-1:0] cur_a;
  logic             bank_fill;
  logic             bank_we;
  logic             mem_we;
  logic             rd_en;
  logic             res_valid;
  res_t             res_new;
  res_t             oq_in;
  logic             oq_push;
  logic             oq_pop;

  // Execute the head command: at most one byte write or one read of the buffer per cycle, beside the start code fill.
  always_comb begin
    wr_now    = step_q ? 1'b1 : (cmd_i.nwr != 2'd0);
    wr_val    = step_q ? cmd_i.v1 : cmd_i.v0;
    last_step = (cmd_i.op == OP_DRAIN) || step_q || (cmd_i.nwr != 2'd2);
    makes_res = (cmd_i.op == OP_DRAIN) || (last_step && (cmd_i.end_class != END_NONE));
    occ       = {1'b0, oq_cnt_q} + {{OQ_CNT_W{1'b0}}, s2_valid_q};
    room      = (occ < (OQ_CNT_W + 1)'(OQ_DEPTH));
    go        = cmd_valid_i && (!makes_res || room);
    do_start  = (cmd_i.op == OP_BYTE) && cmd_i.start && !step_q;
    cur_a     = do_start ? CUR_W'(START_CODE_BYTES) : cur_q;

    cur_d     = cur_q;
    ready_d   = ready_q;
    drain_d   = drain_q;
    err_d     = err_q;
    step_d    = step_q;
    bank_fill = 1'b0;
    bank_we   = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    res_valid = 1'b0;
    res_new   = '0;

    if (go) begin
      if (cmd_i.op == OP_DRAIN) begin
        res_valid = 1'b1;
        if (drain_q < ready_q) begin
          rd_en          = 1'b1;
          res_new.status = ST_DRAIN_BYTE;
          res_new.last   = ((drain_q + CUR_W'(1)) == ready_q);
          res_new.len    = LEN_W'(ready_q);
          if (res_new.last) begin
            ready_d = '0;
            drain_d = '0;
          end else begin
            drain_d = drain_q + CUR_W'(1);
          end
        end else begin
          res_new.status = ST_DRAIN_EMPTY;
        end
      end else begin
        cur_d = cur_a;
        // A start code writes offset zero, which cancels any ready NAL.
        if (do_start) begin
          bank_fill = 1'b1;
          ready_d   = '0;
          drain_d   = '0;
        end
        if (wr_now && !err_q) begin
          if (cur_a >= CUR_W'(BUF_BYTES)) begin
            err_d = 1'b1;
          end else begin
            if (cur_a < ready_d) begin
              ready_d = '0;
              drain_d = '0;
            end
            if (cur_a < CUR_W'(START_CODE_BYTES)) begin
              bank_we = 1'b1;
            end else begin
              mem_we = 1'b1;
            end
            cur_d = cur_a + CUR_W'(1);
          end
        end
        // Datagram end: drop, release, hold or nothing.
        if (last_step && (cmd_i.end_class != END_NONE)) begin
          res_valid = 1'b1;
          if (err_d || (cmd_i.end_class == END_SHORT)) begin
            res_new.status = ST_DROPPED;
            cur_d          = '0;
          end else if (cmd_i.end_class == END_RELEASE) begin
            res_new.len = LEN_W'(cur_d);
            if (cmd_i.pss) begin
              ready_d        = cur_d;
              drain_d        = '0;
              res_new.status = ST_READY;
            end else begin
              res_new.status = ST_HELD;
            end
          end else begin
            res_new.status = ST_NOTHING;
          end
          err_d = 1'b0;
        end
        step_d = !last_step;
      end
    end
  end

  assign cmd_pop_o = go && last_step;

  // Buffer control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= '0;
      ready_q    <= '0;
      drain_q    <= '0;
      err_q      <= 1'b0;
      step_q     <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      cur_q      <= cur_d;
      ready_q    <= ready_d;
      drain_q    <= drain_d;
      err_q      <= err_d;
      step_q     <= step_d;
      s2_valid_q <= res_valid;
    end
  end

  // Start code bank and NAL buffer, with registered reads.
  always_ff @(posedge clk_i) begin
    if (bank_fill) begin
      for (int i = 0; i < START_CODE_BYTES; i++) begin
        bank_q[i] <= (i == START_CODE_BYTES - 1) ? 8'h01 : 8'h00;
      end
    end
    if (bank_we) begin
      bank_q[cur_a[BANK_W-1:0]] <= wr_val;
    end
    if (mem_we) begin
      nal_mem_q[cur_a[ADDR_W-1:0]] <= wr_val;
    end
    if (rd_en) begin
      mem_rd_q  <= nal_mem_q[drain_q[ADDR_W-1:0]];
      bank_rd_q <= bank_q[drain_q[BANK_W-1:0]];
      rd_bank_q <= (drain_q < CUR_W'(START_CODE_BYTES));
    end
    s2_res_q <= res_new;
    s2_mem_q <= rd_en;
  end

  // Result queue.
  always_comb begin
    oq_in      = s2_res_q;
    oq_in.data = s2_mem_q ? (rd_bank_q ? bank_rd_q : mem_rd_q) : 8'h00;
  end

  assign oq_push = s2_valid_q;
  assign empty_o = (oq_cnt_q == '0);
  assign oq_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_head_q <= '0;
      oq_tail_q <= '0;
      oq_cnt_q  <= '0;
    end else begin
      if (oq_push) begin
        oq_tail_q <= (oq_tail_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_tail_q + OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_head_q <= (oq_head_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_head_q + OQ_PTR_W'(1);
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(1);
      end else if (oq_pop && !oq_push) begin
        oq_cnt_q <= oq_cnt_q - OQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_tail_q] <= oq_in;
    end
  end

  assign status_o     = oq_q[oq_head_q].status;
  assign byte_out_o   = oq_q[oq_head_q].data;
  assign byte_last_o  = oq_q[oq_head_q].last;
  assign nal_length_o = oq_q[oq_head_q].len;

  // The drain pointer stays inside the ready NAL, and is zero when none is ready.
  a_drain_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_q < ready_q) || ((ready_q == '0) && (drain_q == '0)))
    else $error("drain pointer outside the ready NAL");

  // A second write step only happens for a two-write byte command still at the head.
  a_step_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q |-> (cmd_valid_i && (cmd_i.op == OP_BYTE) && (cmd_i.nwr == 2'd2)))
    else $error("second write step without a two-write command");

  // The room check keeps the result queue from overflowing.
  a_oq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_push |-> ((oq_cnt_q < OQ_CNT_W'(OQ_DEPTH)) || oq_pop))
    else $error("result queue overflow");

  // The write cursor never passes the end of the buffer.
  a_cur_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= CUR_W'(BUF_BYTES))
    else $error("write cursor beyond buffer");

endmodule

FILE: rtl/rtp_h264_h265_depacketizer.sv
// Top level of the RTP H.264/H.265 depacketizer with Annex-B NAL output.
// One word per cycle unless full; drain results pass the cmd queue, read stage, result queue.
// A word that stores two bytes (start of a single NAL without RTP header, or an H.265 start
// fragment) writes them in turn on the buffer write port; the command queue absorbs this.
// Reset is asynchronous and clears all control state; the NAL buffer is not cleared.
`timescale 1ns / 1ps

module rtp_h264_h265_depacketizer
  import rtpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic             opcode_i,
  input  logic [7:0]       byte_in_i,
  input  logic             datagram_end_i,
  output logic             empty,
  input  logic             pop,
  output logic [2:0]       status_o,
  output logic [7:0]       byte_out_o,
  output logic             byte_last_o,
  output logic [LEN_W-1:0] nal_length_o
);

  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_valid;
  cmd_t cmd_head;
  logic cmd_pop;

  // Classify incoming words.
  rtpd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .opcode_i       (opcode_i),
    .byte_in_i      (byte_in_i),
    .datagram_end_i (datagram_end_i),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in)
  );

  // Decouple the front end from the buffer.
  rtpd_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_head)
  );

  // Buffer writes, release, drain and results.
  rtpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd_head),
    .cmd_pop_o    (cmd_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .status_o     (status_o),
    .byte_out_o   (byte_out_o),
    .byte_last_o  (byte_last_o),
    .nal_length_o (nal_length_o)
  );

endmodule
